// File: design/xyz_velocity_differentiator_defines.svh
// Assertion macros used by the velocity differentiator design.
`ifndef XYZ_VELOCITY_DIFFERENTIATOR_DEFINES_SVH
`define XYZ_VELOCITY_DIFFERENTIATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define XVD_ASSERT_NOW(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define XVD_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// File: design/xvd_pkg.sv
// ----------------------------------------------------------------------------
// xvd_pkg
// Types and constants of the xyz velocity differentiator.
// ----------------------------------------------------------------------------
package xvd_pkg;

    localparam int AXES     = 3;
    localparam int POS_W    = 32;
    localparam int DT_W     = 24;
    localparam int COEF_W   = 24;
    localparam int ACC_W    = 60;
    localparam int NUM_W    = 52;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_A1      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A2      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STARTUP = 3'd3;

    localparam logic signed [COEF_W-1:0] A1_RESET      = 24'sd103088;
    localparam logic signed [COEF_W-1:0] A2_RESET      = 24'sd40554;
    localparam logic signed [COEF_W-1:0] B_RESET       = 24'sd1484390;
    localparam logic [31:0]              STARTUP_RESET = 32'd100000;

    // Microseconds per second, used as the Euler scale factor.
    localparam logic signed [COEF_W-1:0] EULER_SCALE = 24'sd1000000;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [DT_W-1:0]         dt_us;
    } in_t;

    typedef struct packed {
        logic signed [POS_W-1:0] vel_x;
        logic signed [POS_W-1:0] vel_y;
        logic signed [POS_W-1:0] vel_z;
        logic                    filtered_mode;
        logic                    zero_interval;
        logic                    saturated;
    } out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AXIS,
        S_LOAD,
        S_MUL,
        S_DIVSET,
        S_DIV,
        S_FINISH,
        S_DONE
    } state_t;

endpackage

// File: design/xyz_velocity_differentiator.sv
// ----------------------------------------------------------------------------
// xyz_velocity_differentiator
// Euler or second-order filtered velocity estimate from xyz position samples.
// ----------------------------------------------------------------------------
// One sample is processed at a time, axis after axis, through a single
// shift-and-add multiplier that retires one coefficient bit per cycle and a
// restoring divider that retires one quotient bit per cycle. In filtered mode
// an axis takes a setup state, then three 24-bit products, each with its load
// state, and a store state. In Euler mode it takes a setup state, one 24-bit
// product with its load state, a division setup state, a 52-bit division and
// a store state, or only the setup and store states when dt is zero. After
// the last axis the result waits in the done state until the output register
// is free, so a stalled output holds the sequencer; the next sample is taken
// only once it is back in idle. The input is taken again as soon as the
// sequencer is idle, even while the previous result still waits in the output
// register.
`include "xyz_velocity_differentiator_defines.svh"

module xyz_velocity_differentiator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  xvd_pkg::in_t                        in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output xvd_pkg::out_t                       out,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [xvd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [xvd_pkg::CFG_DAT_W-1:0]       cfg_data
);

    localparam int ACC_W = xvd_pkg::ACC_W;
    localparam int NUM_W = xvd_pkg::NUM_W;
    localparam int DT_W  = xvd_pkg::DT_W;
    localparam int POS_W = xvd_pkg::POS_W;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(64'sh8000_0000);
    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(64'sd32768);

    xvd_pkg::state_t state_reg, state_next;

    logic signed [23:0] a1_reg, a2_reg, b_reg;
    logic [31:0]        startup_reg;
    logic [31:0]        elapsed_reg, elapsed_next;

    logic signed [POS_W-1:0] prev_pos_reg [xvd_pkg::AXES];
    logic signed [POS_W-1:0] prev_vel_reg [xvd_pkg::AXES];
    logic signed [POS_W-1:0] old_vel_reg  [xvd_pkg::AXES];
    logic signed [POS_W-1:0] pos_reg      [xvd_pkg::AXES];
    logic signed [POS_W-1:0] vel_reg      [xvd_pkg::AXES];

    logic [DT_W-1:0]         dt_reg;
    logic                    filtered_reg, filtered_next;
    logic                    zero_reg, zero_next;
    logic                    sat_reg, sat_next;

    logic [1:0]              axis_reg, axis_next;
    logic [1:0]              term_reg, term_next;
    logic [4:0]              bit_cnt_reg, bit_cnt_next;
    logic [5:0]              div_cnt_reg, div_cnt_next;

    logic signed [POS_W:0]   diff_reg, diff_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] mcand_reg, mcand_next;
    logic [23:0]             mplier_reg, mplier_next;
    logic                    neg_reg, neg_next;
    logic [NUM_W-1:0]        num_reg, num_next;
    logic [DT_W-1:0]         rem_reg, rem_next;

    logic                    out_valid_reg, out_valid_next;
    xvd_pkg::out_t           out_reg, out_next;

    logic                    store_en;
    logic signed [POS_W-1:0] store_val;

    // Datapath helpers
    logic [32:0]             elapsed_sum;
    logic signed [ACC_W-1:0] pp;
    logic                    sub_pp;
    logic [DT_W:0]           rem_sh;
    logic signed [ACC_W-1:0] mag;
    logic signed [ACC_W-1:0] rounded;
    logic signed [ACC_W-1:0] quot_s;
    logic signed [ACC_W-1:0] final_val;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != xvd_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out       = out_reg;

    assign elapsed_sum = {1'b0, elapsed_reg} + {9'd0, in.dt_us};

    always_comb
    begin
        state_next     = state_reg;
        elapsed_next   = elapsed_reg;
        filtered_next  = filtered_reg;
        zero_next      = zero_reg;
        sat_next       = sat_reg;
        axis_next      = axis_reg;
        term_next      = term_reg;
        bit_cnt_next   = bit_cnt_reg;
        div_cnt_next   = div_cnt_reg;
        diff_next      = diff_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        neg_next       = neg_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        store_en       = 1'b0;
        store_val      = '0;

        pp      = mplier_reg[0] ? mcand_reg : '0;
        sub_pp  = (bit_cnt_reg == 5'd23) ^ neg_reg;
        rem_sh  = {rem_reg, num_reg[NUM_W-1]};
        mag     = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
        rounded = (acc_reg + HALF_LSB) >>> 16;
        quot_s  = neg_reg ? -$signed({8'd0, num_reg}) : $signed({8'd0, num_reg});
        final_val = filtered_reg ? rounded : quot_s;

        unique case (state_reg)
            xvd_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    elapsed_next  = elapsed_sum[32] ? 32'hFFFF_FFFF : elapsed_sum[31:0];
                    filtered_next = (elapsed_next > startup_reg);
                    zero_next     = 1'b0;
                    sat_next      = 1'b0;
                    axis_next     = '0;
                    state_next    = xvd_pkg::S_AXIS;
                end
            end
            xvd_pkg::S_AXIS:
            begin
                diff_next = (POS_W+1)'(pos_reg[axis_reg]) - (POS_W+1)'(prev_pos_reg[axis_reg]);
                acc_next  = '0;
                term_next = filtered_reg ? 2'd0 : 2'd2;
                if (!filtered_reg && dt_reg == '0)
                begin
                    // Euler with no interval: velocity is forced to zero.
                    zero_next  = 1'b1;
                    num_next   = '0;
                    neg_next   = 1'b0;
                    state_next = xvd_pkg::S_FINISH;
                end
                else
                begin
                    state_next = xvd_pkg::S_LOAD;
                end
            end
            xvd_pkg::S_LOAD:
            begin
                bit_cnt_next = '0;
                case (term_reg)
                    2'd0:
                    begin
                        mplier_next = a1_reg;
                        mcand_next  = ACC_W'(prev_vel_reg[axis_reg]);
                        neg_next    = 1'b0;
                    end
                    2'd1:
                    begin
                        mplier_next = a2_reg;
                        mcand_next  = ACC_W'(old_vel_reg[axis_reg]);
                        neg_next    = 1'b1;
                    end
                    default:
                    begin
                        mplier_next = filtered_reg ? b_reg : xvd_pkg::EULER_SCALE;
                        mcand_next  = ACC_W'(diff_reg);
                        neg_next    = 1'b0;
                    end
                endcase
                state_next = xvd_pkg::S_MUL;
            end
            xvd_pkg::S_MUL:
            begin
                // The coefficient's top bit carries negative weight.
                acc_next     = sub_pp ? acc_reg - pp : acc_reg + pp;
                mcand_next   = mcand_reg <<< 1;
                mplier_next  = mplier_reg >> 1;
                bit_cnt_next = bit_cnt_reg + 5'd1;
                if (bit_cnt_reg == 5'd23)
                begin
                    if (term_reg != 2'd2)
                    begin
                        term_next  = term_reg + 2'd1;
                        state_next = xvd_pkg::S_LOAD;
                    end
                    else if (filtered_reg)
                    begin
                        state_next = xvd_pkg::S_FINISH;
                    end
                    else
                    begin
                        state_next = xvd_pkg::S_DIVSET;
                    end
                end
            end
            xvd_pkg::S_DIVSET:
            begin
                neg_next     = acc_reg[ACC_W-1];
                num_next     = mag[NUM_W-1:0];
                rem_next     = '0;
                div_cnt_next = '0;
                state_next   = xvd_pkg::S_DIV;
            end
            xvd_pkg::S_DIV:
            begin
                if (rem_sh >= {1'b0, dt_reg})
                begin
                    rem_next = DT_W'(rem_sh - {1'b0, dt_reg});
                    num_next = {num_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[DT_W-1:0];
                    num_next = {num_reg[NUM_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 6'd1;
                if (div_cnt_reg == 6'(NUM_W - 1))
                    state_next = xvd_pkg::S_FINISH;
            end
            xvd_pkg::S_FINISH:
            begin
                store_en = 1'b1;
                if (final_val > SAT_MAX)
                begin
                    store_val = POS_W'(SAT_MAX);
                    sat_next  = 1'b1;
                end
                else if (final_val < SAT_MIN)
                begin
                    store_val = POS_W'(SAT_MIN);
                    sat_next  = 1'b1;
                end
                else
                begin
                    store_val = POS_W'(final_val);
                end
                if (axis_reg == 2'(xvd_pkg::AXES - 1))
                begin
                    state_next = xvd_pkg::S_DONE;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = xvd_pkg::S_AXIS;
                end
            end
            xvd_pkg::S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next.vel_x         = vel_reg[0];
                    out_next.vel_y         = vel_reg[1];
                    out_next.vel_z         = vel_reg[2];
                    out_next.filtered_mode = filtered_reg;
                    out_next.zero_interval = zero_reg;
                    out_next.saturated     = sat_reg;
                    out_valid_next         = 1'b1;
                    state_next             = xvd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = xvd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= xvd_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            elapsed_reg   <= '0;
            a1_reg        <= xvd_pkg::A1_RESET;
            a2_reg        <= xvd_pkg::A2_RESET;
            b_reg         <= xvd_pkg::B_RESET;
            startup_reg   <= xvd_pkg::STARTUP_RESET;
            for (int i = 0; i < xvd_pkg::AXES; i++)
            begin
                prev_pos_reg[i] <= '0;
                prev_vel_reg[i] <= '0;
                old_vel_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            elapsed_reg   <= elapsed_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    xvd_pkg::REG_A1:      a1_reg      <= cfg_data[23:0];
                    xvd_pkg::REG_A2:      a2_reg      <= cfg_data[23:0];
                    xvd_pkg::REG_B:       b_reg       <= cfg_data[23:0];
                    xvd_pkg::REG_STARTUP: startup_reg <= cfg_data;
                    default:              ;
                endcase
            end
            if (store_en)
            begin
                prev_pos_reg[axis_reg] <= pos_reg[axis_reg];
                old_vel_reg[axis_reg]  <= prev_vel_reg[axis_reg];
                prev_vel_reg[axis_reg] <= store_val;
            end
        end
    end

    // Payload and datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        if (state_reg == xvd_pkg::S_IDLE && in_valid)
        begin
            pos_reg[0] <= in.pos_x;
            pos_reg[1] <= in.pos_y;
            pos_reg[2] <= in.pos_z;
            dt_reg     <= in.dt_us;
        end
        if (store_en)
            vel_reg[axis_reg] <= store_val;
        filtered_reg <= filtered_next;
        zero_reg     <= zero_next;
        sat_reg      <= sat_next;
        axis_reg     <= axis_next;
        term_reg     <= term_next;
        bit_cnt_reg  <= bit_cnt_next;
        div_cnt_reg  <= div_cnt_next;
        diff_reg     <= diff_next;
        acc_reg      <= acc_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        neg_reg      <= neg_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        out_reg      <= out_next;
    end

    `XVD_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_valid && !in_stall, state_reg == xvd_pkg::S_AXIS, "accepted transaction did not start the sequencer")
    `XVD_ASSERT_NOW(a_zero_euler, clk, rst_n, out_valid && out.zero_interval, !out.filtered_mode && !out.saturated, "zero interval flagged with filter or saturation")
    `XVD_ASSERT_NOW(a_zero_vel, clk, rst_n, out_valid && out.zero_interval, out.vel_x == '0 && out.vel_y == '0 && out.vel_z == '0, "zero interval with nonzero velocity")
    `XVD_ASSERT_NOW(a_mul_count, clk, rst_n, state_reg == xvd_pkg::S_MUL, bit_cnt_reg <= 5'd23, "multiplier step count out of range")

endmodule
